>>> rtl/fpdc_pkg.sv
// ----------------------------------------------------------------------------
// fpdc_pkg
// Shared constants and types of the fractional-N PLL divider calculation.
// ----------------------------------------------------------------------------
package fpdc_pkg;

    localparam int unsigned FREQ_W  = 32;
    localparam int unsigned XO_W    = 26;
    localparam int unsigned BAND_W  = 3;
    localparam int unsigned INT_W   = 7;
    localparam int unsigned FRAC_W  = 20;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_W   = 33;
    localparam int unsigned DEN_W   = 28;
    localparam int unsigned QI_W    = 8;
    localparam int unsigned QF_W    = 19;
    localparam int unsigned Q_W     = QI_W + QF_W;
    localparam int unsigned NCELLS  = Q_W;
    localparam int unsigned ODIV_W  = 5;
    localparam int unsigned TDATA_W = 64;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [FREQ_W-1:0] FREQ_MIN_HZ   = 32'd119000000;
    localparam logic [FREQ_W-1:0] FREQ_MAX_HZ   = 32'd1050000000;
    localparam logic [FREQ_W-1:0] EDGE_DIV4_HZ  = 32'd705000000;
    localparam logic [FREQ_W-1:0] EDGE_DIV6_HZ  = 32'd525000000;
    localparam logic [FREQ_W-1:0] EDGE_DIV8_HZ  = 32'd353000000;
    localparam logic [FREQ_W-1:0] EDGE_DIV12_HZ = 32'd239000000;
    localparam logic [FREQ_W-1:0] EDGE_DIV16_HZ = 32'd177000000;

    localparam logic [BAND_W-1:0] BAND_DIV4  = 3'd0;
    localparam logic [BAND_W-1:0] BAND_DIV6  = 3'd1;
    localparam logic [BAND_W-1:0] BAND_DIV8  = 3'd2;
    localparam logic [BAND_W-1:0] BAND_DIV12 = 3'd3;
    localparam logic [BAND_W-1:0] BAND_DIV16 = 3'd4;
    localparam logic [BAND_W-1:0] BAND_DIV24 = 3'd5;

    localparam logic [QI_W-1:0] Q_MAX = 8'd128;

    localparam logic [XO_W-1:0] XO_RESET = 26'd30000000;

    // register select, taken from paddr[2]
    localparam logic REG_XO  = 1'b0;
    localparam logic REG_PSC = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              err;
        logic [BAND_W-1:0] band;
        logic              sel;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [Q_W-1:0]    sh;   // dividend bits out at the top, quotient bits in at the bottom
    } t_cell;

endpackage

>>> rtl/fpdc_prep.sv
// ----------------------------------------------------------------------------
// fpdc_prep
// Range check, band select, numerator/denominator build and divider load.
// ----------------------------------------------------------------------------
module fpdc_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [fpdc_pkg::FREQ_W-1:0]  i_freq,
    input  logic [fpdc_pkg::XO_W-1:0]    i_xo,
    input  logic                         i_psc,
    output fpdc_pkg::t_cell              o_cell
);
    import fpdc_pkg::*;

    logic                r_a_valid;
    logic                r_a_err;
    logic [BAND_W-1:0]   r_a_band;
    logic                r_a_sel;
    logic [NUM_W-1:0]    r_a_num;
    logic [DEN_W-1:0]    r_a_den;

    logic                n_a_err;
    logic [BAND_W-1:0]   n_a_band;
    logic [ODIV_W-1:0]   w_odiv;
    logic [FREQ_W+ODIV_W-1:0] w_prod;
    logic [DEN_W-1:0]    n_a_den;

    t_cell               r_b;
    t_cell               n_b;
    logic                w_ovf;

    always_comb begin
        n_a_err = (i_freq < FREQ_MIN_HZ) || (i_freq > FREQ_MAX_HZ);
        if (i_freq >= EDGE_DIV4_HZ) begin
            n_a_band = BAND_DIV4;  w_odiv = 5'd4;
        end else if (i_freq >= EDGE_DIV6_HZ) begin
            n_a_band = BAND_DIV6;  w_odiv = 5'd6;
        end else if (i_freq >= EDGE_DIV8_HZ) begin
            n_a_band = BAND_DIV8;  w_odiv = 5'd8;
        end else if (i_freq >= EDGE_DIV12_HZ) begin
            n_a_band = BAND_DIV12; w_odiv = 5'd12;
        end else if (i_freq >= EDGE_DIV16_HZ) begin
            n_a_band = BAND_DIV16; w_odiv = 5'd16;
        end else begin
            n_a_band = BAND_DIV24; w_odiv = 5'd24;
        end
        w_prod  = (FREQ_W+ODIV_W)'(i_freq) * (FREQ_W+ODIV_W)'(w_odiv);
        n_a_den = i_psc ? {i_xo, 2'b00} : {1'b0, i_xo, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_err  <= n_a_err;
            r_a_band <= n_a_band;
            r_a_sel  <= ~i_psc;
            r_a_num  <= w_prod[NUM_W-1:0];
            r_a_den  <= n_a_den;
        end
    end

    // quotient must fit in QI_W integer bits, else error (covers zero denominator)
    always_comb begin
        w_ovf       = {3'b000, r_a_num} >= {r_a_den, 8'h00};
        n_b.valid   = r_a_valid;
        n_b.err     = r_a_err | w_ovf;
        n_b.band    = r_a_band;
        n_b.sel     = r_a_sel;
        n_b.den     = r_a_den;
        n_b.rem     = {3'b000, r_a_num[NUM_W-1:QI_W]};
        n_b.sh      = {r_a_num[QI_W-1:0], {QF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_b.valid <= n_b.valid;
        end
        if (i_en) begin
            r_b.err  <= n_b.err;
            r_b.band <= n_b.band;
            r_b.sel  <= n_b.sel;
            r_b.den  <= n_b.den;
            r_b.rem  <= n_b.rem;
            r_b.sh   <= n_b.sh;
        end
    end

    assign o_cell = r_b;

endmodule

>>> rtl/fpdc_div_cell.sv
// ----------------------------------------------------------------------------
// fpdc_div_cell
// One restoring-division step: shift in a dividend bit, trial subtract,
// shift the quotient bit into the carried word.
// ----------------------------------------------------------------------------
module fpdc_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  fpdc_pkg::t_cell i_cell,
    output fpdc_pkg::t_cell o_cell
);
    import fpdc_pkg::*;

    t_cell            r_cell;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [DEN_W-1:0] n_rem;
    logic [Q_W-1:0]   n_sh;

    always_comb begin
        w_trial = {i_cell.rem, i_cell.sh[Q_W-1]};
        w_ge    = w_trial >= {1'b0, i_cell.den};
        w_diff  = w_trial - {1'b0, i_cell.den};
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_sh    = {i_cell.sh[Q_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.err  <= i_cell.err;
            r_cell.band <= i_cell.band;
            r_cell.sel  <= i_cell.sel;
            r_cell.den  <= i_cell.den;
            r_cell.rem  <= n_rem;
            r_cell.sh   <= n_sh;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> rtl/fpdc_out.sv
// ----------------------------------------------------------------------------
// fpdc_out
// Final range check, result packing, output register and skid stage.
// ----------------------------------------------------------------------------
module fpdc_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fpdc_pkg::t_cell              i_tail,
    input  logic                         i_ready,
    output logic                         o_en,
    output logic                         o_valid,
    output logic [fpdc_pkg::TDATA_W-1:0] o_data,
    output logic                         o_user
);
    import fpdc_pkg::*;

    logic [QI_W-1:0]    w_q;
    logic               w_err;
    logic [INT_W-1:0]   w_n;
    logic [QI_W-1:0]    w_nm1;
    logic [FRAC_W-1:0]  w_m;
    logic [WORD_W-1:0]  w_word;
    logic [TDATA_W-1:0] w_data;
    logic               w_in_v;

    logic               r_out_valid;
    logic [TDATA_W-1:0] r_out_data;
    logic               r_out_err;
    logic               r_skid_valid;
    logic [TDATA_W-1:0] r_skid_data;
    logic               r_skid_err;

    always_comb begin
        w_q    = i_tail.sh[Q_W-1:QF_W];
        w_err  = i_tail.err || (w_q == '0) || (w_q > Q_MAX);
        w_nm1  = w_q - 8'd1;
        w_n    = w_nm1[INT_W-1:0];
        w_m    = {1'b1, i_tail.sh[QF_W-1:0]};
        w_word = {1'b0, w_n, 4'h0, w_m};
        if (w_err) begin
            w_data = '0;
        end else begin
            w_data = {1'b0, w_word, w_m, w_n, i_tail.sel, i_tail.band};
        end
    end

    assign o_en   = ~r_skid_valid;
    assign w_in_v = i_tail.valid & o_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_v;
            end
        end else if (w_in_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_err  <= r_skid_err;
            end else begin
                r_out_data <= w_data;
                r_out_err  <= w_err;
            end
        end else if (w_in_v) begin
            r_skid_data <= w_data;
            r_skid_err  <= w_err;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_err;

endmodule

>>> rtl/fracn_pll_divider_calc_unit.sv
// ----------------------------------------------------------------------------
// fracn_pll_divider_calc_unit
// Pipeline: 2 prep stages, 27 division cells, 1 output register. Throughput:
// one item per cycle while the skid stage is empty (a full skid stage stalls
// prep and cells); the cell chain yields one quotient bit per cell per cycle.
// Reset (synchronous, active low) empties the pipeline and skid stage and
// loads xo_frequency_hz = 30000000, prescaler_mode = 0.
// ----------------------------------------------------------------------------
module fracn_pll_divider_calc_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [fpdc_pkg::FREQ_W-1:0]  s_tdata,   // [31:0] frequency_hz
    // master stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [2:0] band_code, [3] synth_select, [10:4] integer_part,
    // [30:11] fraction_part, [62:31] divider_word, [63] zero
    output logic [fpdc_pkg::TDATA_W-1:0] m_tdata,
    output logic                         m_tuser,   // [0] range_error
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fpdc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fpdc_pkg::*;

    logic            w_reg_sel;
    logic [XO_W-1:0] r_xo_hz;
    logic            r_psc;
    logic            w_wr;
    logic            w_en;
    t_cell           w_chain [0:NCELLS];

    assign pready    = 1'b1;
    assign w_wr      = psel & penable & pwrite;
    assign w_reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xo_hz <= XO_RESET;
            r_psc   <= 1'b0;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                REG_XO:  r_xo_hz <= pwdata[XO_W-1:0];
                REG_PSC: r_psc   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_XO:  prdata = {{(32-XO_W){1'b0}}, r_xo_hz};
            REG_PSC: prdata = {31'd0, r_psc};
            default: prdata = '0;
        endcase
    end

    assign s_tready = w_en;

    fpdc_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_tvalid),
        .i_freq  (s_tdata),
        .i_xo    (r_xo_hz),
        .i_psc   (r_psc),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        fpdc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    fpdc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tail  (w_chain[NCELLS]),
        .i_ready (m_tready),
        .o_en    (w_en),
        .o_valid (m_tvalid),
        .o_data  (m_tdata),
        .o_user  (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries nonzero fields");

    a_frac_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata[30] && m_tdata[50])
        else $error("good result with fraction below one");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled while output register empty");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready && m_tready |=> s_tready)
        else $error("skid stage not drained");
`endif

endmodule
